### rtl/tvpd_pkg.sv
package tvpd_pkg;

  // default geometry of one frame
  localparam int PACKET_BYTES_DEF = 164;
  localparam int ROWS_DEF         = 60;
  localparam int HEADER_WORDS_DEF = 2;

  // field widths
  localparam int BYTE_W  = 8;
  localparam int PIXEL_W = 16;
  localparam int ROW_W   = 6;
  localparam int COL_W   = 7;
  localparam int COUNT_W = 16;

  localparam logic [COUNT_W-1:0] SYNC_LOSS_LIMIT_RESET = 16'd750;
  localparam logic [COUNT_W-1:0] COUNT_MAX             = 16'hFFFF;
  localparam logic [PIXEL_W-1:0] PIXEL_MAX             = 16'hFFFF;

  typedef struct packed {
    logic               pixel_valid;
    logic [PIXEL_W-1:0] pixel_value;
    logic [ROW_W-1:0]   pixel_row;
    logic [COL_W-1:0]   pixel_col;
    logic               frame_done;
    logic [PIXEL_W-1:0] frame_min;
    logic [PIXEL_W-1:0] frame_max;
    logic               lost_sync;
    logic               resync_request;
    logic [COUNT_W-1:0] sync_loss_total;
    logic [COUNT_W-1:0] restart_total;
  } result_t;

endpackage

### rtl/tvpd_if.sv
// byte stream from the serial link
interface tvpd_byte_if;
  logic                      valid;
  logic                      ready;
  logic [tvpd_pkg::BYTE_W-1:0] spi_byte;

  modport source (output valid, output spi_byte, input ready);
  modport sink   (input valid, input spi_byte, output ready);
endinterface

// pixel and sync status results
interface tvpd_result_if;
  logic                         valid;
  logic                         ready;
  logic                         pixel_valid;
  logic [tvpd_pkg::PIXEL_W-1:0] pixel_value;
  logic [tvpd_pkg::ROW_W-1:0]   pixel_row;
  logic [tvpd_pkg::COL_W-1:0]   pixel_col;
  logic                         frame_done;
  logic [tvpd_pkg::PIXEL_W-1:0] frame_min;
  logic [tvpd_pkg::PIXEL_W-1:0] frame_max;
  logic                         lost_sync;
  logic                         resync_request;
  logic [tvpd_pkg::COUNT_W-1:0] sync_loss_total;
  logic [tvpd_pkg::COUNT_W-1:0] restart_total;

  modport source (output valid, output pixel_valid, output pixel_value, output pixel_row,
                  output pixel_col, output frame_done, output frame_min, output frame_max,
                  output lost_sync, output resync_request, output sync_loss_total,
                  output restart_total, input ready);
  modport sink   (input valid, input pixel_valid, input pixel_value, input pixel_row,
                  input pixel_col, input frame_done, input frame_min, input frame_max,
                  input lost_sync, input resync_request, input sync_loss_total,
                  input restart_total, output ready);
endinterface

// sync loss limit register write
interface tvpd_cfg_if;
  logic                         valid;
  logic                         ready;
  logic [tvpd_pkg::COUNT_W-1:0] sync_loss_limit;

  modport source (output valid, output sync_loss_limit, input ready);
  modport sink   (input valid, input sync_loss_limit, output ready);
endinterface

### rtl/thermal_video_packet_deframer_unit.sv
// channel   | dir | payload                                   | accepted when
// ----------+-----+-------------------------------------------+----------------------
// pkt_in    | in  | spi_byte                                  | valid & ready
// pix_out   | out | pixel / frame / sync status fields        | valid & ready
// cfg       | in  | sync_loss_limit                           | valid & ready
//
// one byte per cycle unless stalled: each beat goes through one compare, counter and
// min/max step straight into the result register, so a result appears in the cycle
// after its byte. pkt_in is stalled only while a result waits in the output register
// and pix_out is not ready. rst (synchronous, active high) clears the packet position,
// row, counters and min/max and sets the limit to 750. cfg is always ready; the user
// must write it only while the block is idle, which the block itself does not enforce.
module thermal_video_packet_deframer_unit #(
  parameter int PACKET_BYTES = tvpd_pkg::PACKET_BYTES_DEF,
  parameter int ROWS         = tvpd_pkg::ROWS_DEF,
  parameter int HEADER_WORDS = tvpd_pkg::HEADER_WORDS_DEF
) (
  input  logic           clk,
  input  logic           rst,
  tvpd_byte_if.sink      pkt_in,
  tvpd_result_if.source  pix_out,
  tvpd_cfg_if.sink       cfg
);

  localparam int POS_W         = tvpd_pkg::BYTE_W;
  localparam int PIX_START     = 2 * HEADER_WORDS;
  localparam int COLS          = (PACKET_BYTES - PIX_START) / 2;
  localparam int LAST_PIX_BYTE = PIX_START + 2 * COLS - 1;

  localparam logic [POS_W-1:0] POS_HEADER_ROW = POS_W'(1);
  localparam logic [POS_W-1:0] POS_PIX_START  = POS_W'(PIX_START);
  localparam logic [POS_W-1:0] POS_LAST_PIX   = POS_W'(LAST_PIX_BYTE);
  localparam logic [POS_W:0]   POS_WRAP       = (POS_W + 1)'(PACKET_BYTES);
  localparam logic [tvpd_pkg::ROW_W:0] ROW_LIMIT = (tvpd_pkg::ROW_W + 1)'(ROWS);

  // packet and frame state
  logic [POS_W-1:0]             byte_position,   byte_position_next;
  logic [tvpd_pkg::ROW_W-1:0]   expected_row,    expected_row_next;
  logic                         packet_good,     packet_good_next;
  logic [tvpd_pkg::BYTE_W-1:0]  high_byte_hold,  high_byte_hold_next;
  logic [tvpd_pkg::COUNT_W-1:0] sync_loss_count, sync_loss_count_next;
  logic [tvpd_pkg::COUNT_W-1:0] restart_count,   restart_count_next;
  logic [tvpd_pkg::PIXEL_W-1:0] running_min,     running_min_next;
  logic [tvpd_pkg::PIXEL_W-1:0] running_max,     running_max_next;
  logic [tvpd_pkg::COUNT_W-1:0] sync_loss_limit;

  // result register
  logic                         res_valid;
  tvpd_pkg::result_t            res;
  tvpd_pkg::result_t            res_next;
  logic                         has_result;

  logic                         in_beat;
  logic [POS_W:0]               pos_inc;
  logic [POS_W-1:0]             pix_off;
  logic [tvpd_pkg::PIXEL_W-1:0] pix;
  logic [tvpd_pkg::COUNT_W-1:0] loss_inc;
  logic                         limit_hit;

  // a waiting result blocks new bytes only when it cannot leave this cycle
  assign pkt_in.ready = !res_valid || pix_out.ready;
  assign in_beat      = pkt_in.valid && pkt_in.ready;
  assign cfg.ready    = 1'b1;

  assign pos_inc   = {1'b0, byte_position} + (POS_W + 1)'(1);
  assign pix_off   = byte_position - POS_PIX_START;
  assign pix       = {high_byte_hold, pkt_in.spi_byte};
  assign loss_inc  = (sync_loss_count != tvpd_pkg::COUNT_MAX) ?
                     sync_loss_count + tvpd_pkg::COUNT_W'(1) : sync_loss_count;
  assign limit_hit = loss_inc >= sync_loss_limit;

  always_comb begin
    byte_position_next   = (pos_inc >= POS_WRAP) ? '0 : pos_inc[POS_W-1:0];
    expected_row_next    = expected_row;
    packet_good_next     = packet_good;
    high_byte_hold_next  = high_byte_hold;
    sync_loss_count_next = sync_loss_count;
    restart_count_next   = restart_count;
    running_min_next     = running_min;
    running_max_next     = running_max;
    res_next             = '0;
    has_result           = 1'b0;

    if (byte_position == '0) begin
      packet_good_next = 1'b1;
    end else if (byte_position == POS_HEADER_ROW) begin
      // row number check, any byte of 64 or above is a mismatch
      if (pkt_in.spi_byte != {2'b00, expected_row}) begin
        packet_good_next  = 1'b0;
        expected_row_next = '0;
        running_min_next  = tvpd_pkg::PIXEL_MAX;
        running_max_next  = '0;
        if (limit_hit) begin
          sync_loss_count_next = '0;
          if (restart_count != tvpd_pkg::COUNT_MAX) begin
            restart_count_next = restart_count + tvpd_pkg::COUNT_W'(1);
          end
        end else begin
          sync_loss_count_next = loss_inc;
        end
        has_result               = 1'b1;
        res_next.lost_sync       = 1'b1;
        res_next.resync_request  = limit_hit;
        res_next.sync_loss_total = sync_loss_count_next;
        res_next.restart_total   = restart_count_next;
      end
    end else if (packet_good && byte_position >= POS_PIX_START &&
                 byte_position <= POS_LAST_PIX) begin
      if (!pix_off[0]) begin
        high_byte_hold_next = pkt_in.spi_byte;
      end else begin
        running_min_next = (pix < running_min) ? pix : running_min;
        running_max_next = (pix > running_max) ? pix : running_max;
        has_result               = 1'b1;
        res_next.pixel_valid     = 1'b1;
        res_next.pixel_value     = pix;
        res_next.pixel_row       = expected_row;
        res_next.pixel_col       = pix_off[tvpd_pkg::COL_W:1];
        res_next.sync_loss_total = sync_loss_count;
        res_next.restart_total   = restart_count;
        if (byte_position == POS_LAST_PIX) begin
          packet_good_next = 1'b0;
          if ({1'b0, expected_row} + (tvpd_pkg::ROW_W + 1)'(1) >= ROW_LIMIT) begin
            // last row done, report and start a fresh frame
            res_next.frame_done  = 1'b1;
            res_next.frame_min   = running_min_next;
            res_next.frame_max   = running_max_next;
            sync_loss_count_next = '0;
            restart_count_next   = '0;
            expected_row_next    = '0;
            running_min_next     = tvpd_pkg::PIXEL_MAX;
            running_max_next     = '0;
          end else begin
            expected_row_next = expected_row + tvpd_pkg::ROW_W'(1);
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_position   <= '0;
      expected_row    <= '0;
      packet_good     <= 1'b0;
      high_byte_hold  <= '0;
      sync_loss_count <= '0;
      restart_count   <= '0;
      running_min     <= tvpd_pkg::PIXEL_MAX;
      running_max     <= '0;
      sync_loss_limit <= tvpd_pkg::SYNC_LOSS_LIMIT_RESET;
      res_valid       <= 1'b0;
    end else begin
      if (cfg.valid) begin
        sync_loss_limit <= cfg.sync_loss_limit;
      end
      if (in_beat) begin
        byte_position   <= byte_position_next;
        expected_row    <= expected_row_next;
        packet_good     <= packet_good_next;
        high_byte_hold  <= high_byte_hold_next;
        sync_loss_count <= sync_loss_count_next;
        restart_count   <= restart_count_next;
        running_min     <= running_min_next;
        running_max     <= running_max_next;
        res_valid       <= has_result;
      end else if (pix_out.ready) begin
        res_valid <= 1'b0;
      end
    end
  end

  // payload only, loaded with every accepted byte
  always_ff @(posedge clk) begin
    if (in_beat) begin
      res <= res_next;
    end
  end

  assign pix_out.valid           = res_valid;
  assign pix_out.pixel_valid     = res.pixel_valid;
  assign pix_out.pixel_value     = res.pixel_value;
  assign pix_out.pixel_row       = res.pixel_row;
  assign pix_out.pixel_col       = res.pixel_col;
  assign pix_out.frame_done      = res.frame_done;
  assign pix_out.frame_min       = res.frame_min;
  assign pix_out.frame_max       = res.frame_max;
  assign pix_out.lost_sync       = res.lost_sync;
  assign pix_out.resync_request  = res.resync_request;
  assign pix_out.sync_loss_total = res.sync_loss_total;
  assign pix_out.restart_total   = res.restart_total;

endmodule

### tb/sv/tvpd_deframe_checker.sv
module tvpd_deframe_checker (
  input  logic   clk,
  input  logic   rst,
  tvpd_byte_if   byte_ch,
  tvpd_result_if res_ch,
  tvpd_cfg_if    cfg_ch,
  output int     mismatches,
  output int     outstanding
);
  import tvpd_pkg::*;

  localparam int PIX_FIRST = 2 * HEADER_WORDS_DEF;
  localparam int COLS      = (PACKET_BYTES_DEF - PIX_FIRST) / 2;
  localparam int PIX_LAST  = PIX_FIRST + 2 * COLS - 1;

  logic [COUNT_W-1:0] loss_limit;
  logic [7:0]         byte_pos;
  logic [ROW_W-1:0]   row_expected;
  logic               in_good_packet;
  logic [BYTE_W-1:0]  upper_byte;
  logic [COUNT_W-1:0] loss_count;
  logic [COUNT_W-1:0] restart_count;
  logic [PIXEL_W-1:0] frame_lo;
  logic [PIXEL_W-1:0] frame_hi;
  result_t            awaited_results[$];

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("%0t: mismatch on %s, got %0h, want %0h", $time, what, got, want);
    mismatches++;
  endtask

  task automatic restart_frame();
    row_expected = '0;
    frame_lo     = PIXEL_MAX;
    frame_hi     = '0;
  endtask

  // compare the beat on the result channel with the oldest prediction
  task automatic check_result();
    result_t want;
    if (awaited_results.size() == 0) begin
      report_mismatch("result with nothing awaited", res_ch.pixel_value, 0);
      return;
    end
    want = awaited_results.pop_front();
    if (res_ch.pixel_valid !== want.pixel_valid)
      report_mismatch("pixel_valid", res_ch.pixel_valid, want.pixel_valid);
    if (res_ch.pixel_value !== want.pixel_value)
      report_mismatch("pixel_value", res_ch.pixel_value, want.pixel_value);
    if (res_ch.pixel_row !== want.pixel_row)
      report_mismatch("pixel_row", res_ch.pixel_row, want.pixel_row);
    if (res_ch.pixel_col !== want.pixel_col)
      report_mismatch("pixel_col", res_ch.pixel_col, want.pixel_col);
    if (res_ch.frame_done !== want.frame_done)
      report_mismatch("frame_done", res_ch.frame_done, want.frame_done);
    if (res_ch.frame_min !== want.frame_min)
      report_mismatch("frame_min", res_ch.frame_min, want.frame_min);
    if (res_ch.frame_max !== want.frame_max)
      report_mismatch("frame_max", res_ch.frame_max, want.frame_max);
    if (res_ch.lost_sync !== want.lost_sync)
      report_mismatch("lost_sync", res_ch.lost_sync, want.lost_sync);
    if (res_ch.resync_request !== want.resync_request)
      report_mismatch("resync_request", res_ch.resync_request, want.resync_request);
    if (res_ch.sync_loss_total !== want.sync_loss_total)
      report_mismatch("sync_loss_total", res_ch.sync_loss_total, want.sync_loss_total);
    if (res_ch.restart_total !== want.restart_total)
      report_mismatch("restart_total", res_ch.restart_total, want.restart_total);
  endtask

  // one byte of the stream through the deframer
  task automatic deframe_byte(input logic [BYTE_W-1:0] b);
    result_t            r;
    int                 offset;
    logic [PIXEL_W-1:0] pix;
    r = '0;
    if (byte_pos == 0) begin
      in_good_packet = 1'b1;
    end else if (byte_pos == 1) begin
      if (b != 8'(row_expected)) begin
        in_good_packet = 1'b0;
        restart_frame();
        if (loss_count != COUNT_MAX) loss_count = loss_count + COUNT_W'(1);
        r.lost_sync = 1'b1;
        if (loss_count >= loss_limit) begin
          r.resync_request = 1'b1;
          loss_count = '0;
          if (restart_count != COUNT_MAX) restart_count = restart_count + COUNT_W'(1);
        end
        r.sync_loss_total = loss_count;
        r.restart_total   = restart_count;
        awaited_results.push_back(r);
      end
    end else if (in_good_packet && byte_pos >= PIX_FIRST && byte_pos <= PIX_LAST) begin
      offset = int'(byte_pos) - PIX_FIRST;
      if (offset % 2 == 0) begin
        upper_byte = b;
      end else begin
        pix = {upper_byte, b};
        if (pix < frame_lo) frame_lo = pix;
        if (pix > frame_hi) frame_hi = pix;
        r.pixel_valid     = 1'b1;
        r.pixel_value     = pix;
        r.pixel_row       = row_expected;
        r.pixel_col       = COL_W'(offset / 2);
        r.sync_loss_total = loss_count;
        r.restart_total   = restart_count;
        if (byte_pos == PIX_LAST) begin
          in_good_packet = 1'b0;
          if (int'(row_expected) + 1 >= ROWS_DEF) begin
            r.frame_done  = 1'b1;
            r.frame_min   = frame_lo;
            r.frame_max   = frame_hi;
            loss_count    = '0;
            restart_count = '0;
            restart_frame();
          end else begin
            row_expected = row_expected + ROW_W'(1);
          end
        end
        awaited_results.push_back(r);
      end
    end
    byte_pos = (int'(byte_pos) + 1 >= PACKET_BYTES_DEF) ? '0 : byte_pos + 8'(1);
  endtask

  always @(posedge clk) begin
    if (rst) begin
      loss_limit     = SYNC_LOSS_LIMIT_RESET;
      byte_pos       = '0;
      in_good_packet = 1'b0;
      upper_byte     = '0;
      loss_count     = '0;
      restart_count  = '0;
      restart_frame();
      awaited_results.delete();
    end else begin
      if (res_ch.valid && res_ch.ready) check_result();
      if (cfg_ch.valid && cfg_ch.ready) loss_limit = cfg_ch.sync_loss_limit;
      if (byte_ch.valid && byte_ch.ready) deframe_byte(byte_ch.spi_byte);
    end
    outstanding = awaited_results.size();
  end

endmodule

### tb/sv/testbench.sv
module testbench;
  import tvpd_pkg::*;

  // packet geometry as built into the block
  localparam int PIX_FIRST    = 2 * HEADER_WORDS_DEF;
  localparam int COLS         = (PACKET_BYTES_DEF - PIX_FIRST) / 2;
  localparam int SETTLE       = 4;       // a result comes out in the cycle after its byte
  localparam int HOLD_CYCLES  = 300;     // long receiver hold-off
  localparam int MIXED_PKTS   = 1;       // mixed packets per phase
  localparam int END_LIMIT    = 100000;  // bound on the final drain

  logic clk = 1'b0;
  logic rst;

  tvpd_byte_if   pkt_in ();
  tvpd_result_if pix_out ();
  tvpd_cfg_if    cfg ();

  int mismatch_total;
  int results_awaited;

  // sender and receiver behaviour for the current phase
  int gap_pct;
  int stall_pct;

  // long hold-off: the stimulus bumps the ticket, the receiver serves it
  int hold_ticket;
  int hold_served;
  int hold_left;

  // row the stimulus believes the block expects next
  int row_next;

  // pixels to place at the start of the next packet
  logic [PIXEL_W-1:0] preset_pixels[$];

  thermal_video_packet_deframer_unit dut (
    .clk     (clk),
    .rst     (rst),
    .pkt_in  (pkt_in),
    .pix_out (pix_out),
    .cfg     (cfg)
  );

  tvpd_deframe_checker deframe_check (
    .clk         (clk),
    .rst         (rst),
    .byte_ch     (pkt_in),
    .res_ch      (pix_out),
    .cfg_ch      (cfg),
    .mismatches  (mismatch_total),
    .outstanding (results_awaited)
  );

  always #5 clk = ~clk;

  // run guard: far beyond the slowest correct run
  initial begin
    #15000000;
    $display("** thermal_video_packet_deframer_unit: FAILED **");
    $finish;
  end

  // receiver: random stalls, or a long hold-off when one is requested
  always @(posedge clk) begin
    if (rst) begin
      pix_out.ready <= 1'b0;
    end else if (hold_left > 0) begin
      pix_out.ready <= 1'b0;
      hold_left     <= hold_left - 1;
    end else if (hold_ticket != hold_served) begin
      pix_out.ready <= 1'b0;
      hold_served   <= hold_ticket;
      hold_left     <= HOLD_CYCLES;
    end else begin
      pix_out.ready <= ($urandom_range(0, 99) >= stall_pct);
    end
  end

  // one byte beat, with a random idle gap in front of it
  task automatic put_byte(input logic [BYTE_W-1:0] b);
    if ($urandom_range(0, 99) < gap_pct) begin
      pkt_in.valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(0, 99) < gap_pct);
    end
    pkt_in.valid    <= 1'b1;
    pkt_in.spi_byte <= b;
    @(posedge clk);
    while (!pkt_in.ready) @(posedge clk);
  endtask

  // pixel values lean towards the extremes now and then
  function automatic logic [PIXEL_W-1:0] pick_pixel();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return PIXEL_MAX;
      2:       return PIXEL_W'($urandom_range(0, 15));
      3:       return PIXEL_MAX - PIXEL_W'($urandom_range(0, 15));
      default: return PIXEL_W'($urandom_range(0, 65535));
    endcase
  endfunction

  // a whole packet with the given row byte; header random, pixels preset or random
  task automatic send_packet(input logic [BYTE_W-1:0] row_byte);
    logic [PIXEL_W-1:0] pix;
    int                 i;
    put_byte(BYTE_W'($urandom_range(0, 255)));
    put_byte(row_byte);
    for (i = 2; i < PIX_FIRST; i++) put_byte(BYTE_W'($urandom_range(0, 255)));
    for (i = 0; i < COLS; i++) begin
      pix = (preset_pixels.size() != 0) ? preset_pixels.pop_front() : pick_pixel();
      put_byte(pix[15:8]);
      put_byte(pix[7:0]);
    end
    // any trailing byte that cannot form a pixel
    for (i = PIX_FIRST + 2 * COLS; i < PACKET_BYTES_DEF; i++)
      put_byte(BYTE_W'($urandom_range(0, 255)));
    // a match moves on one row, wrapping after the last; a miss restarts at row 0
    if (row_byte == 8'(row_next))
      row_next = (row_next + 1 >= ROWS_DEF) ? 0 : row_next + 1;
    else
      row_next = 0;
  endtask

  task automatic good_packet();
    send_packet(8'(row_next));
  endtask

  // wrong row byte: far out of range, next row along, or anything else
  task automatic bad_packet();
    logic [BYTE_W-1:0] r;
    do begin
      case ($urandom_range(0, 3))
        0:       r = BYTE_W'($urandom_range(64, 255));
        1:       r = BYTE_W'((row_next + 1) % 64);
        2:       r = BYTE_W'($urandom_range(0, ROWS_DEF - 1));
        default: r = BYTE_W'($urandom_range(0, 255));
      endcase
    end while (r == 8'(row_next));
    send_packet(r);
  endtask

  // stop offering and wait until every predicted result has come out
  task automatic drain();
    pkt_in.valid <= 1'b0;
    do @(posedge clk); while (results_awaited != 0);
    repeat (SETTLE) @(posedge clk);
  endtask

  // limit register write, only ever with the block idle
  task automatic set_limit(input logic [COUNT_W-1:0] limit);
    drain();
    cfg.valid           <= 1'b1;
    cfg.sync_loss_limit <= limit;
    @(posedge clk);
    while (!cfg.ready) @(posedge clk);
    cfg.valid <= 1'b0;
  endtask

  // mostly good packets with the odd broken one
  task automatic run_phase(input int gap, input int stall, input logic [COUNT_W-1:0] limit,
                           input bit squeeze);
    set_limit(limit);
    gap_pct   = gap;
    stall_pct = stall;
    repeat (MIXED_PKTS) begin
      if ($urandom_range(0, 99) < 85) good_packet();
      else bad_packet();
    end
    if (squeeze) begin
      // receiver holds off while the sender keeps offering, so the input stalls
      hold_ticket <= hold_ticket + 1;
      good_packet();
      // then the sender pauses until the block has emptied out
      drain();
    end
  endtask

  initial begin
    int waited;
    rst                 = 1'b1;
    pkt_in.valid        = 1'b0;
    pkt_in.spi_byte     = '0;
    cfg.valid           = 1'b0;
    cfg.sync_loss_limit = '0;
    gap_pct             = 0;
    stall_pct           = 0;
    row_next            = 0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // directed: pixel extremes in row 0 at the reset limit
    preset_pixels = '{16'h0000, 16'hFFFF, 16'h00FF, 16'hFF00,
                      16'h8000, 16'h7FFF, 16'h0001, 16'hFFFE};
    good_packet();
    // limit of 1: every sync loss asks for a resync; row byte all ones
    set_limit(16'd1);
    send_packet(8'hFF);

    // random phases with differing idling and limits
    run_phase(0,  0,  16'd1,  1'b1);
    run_phase(79, 0,  16'd3,  1'b0);
    run_phase(0,  79, 16'hFFFF, 1'b0);
    run_phase(26, 26, COUNT_W'($urandom_range(1, 6)), 1'b0);

    // end of stimulus: let the last results out, within a bound
    pkt_in.valid <= 1'b0;
    waited = 0;
    do begin
      @(posedge clk);
      waited++;
    end while (results_awaited != 0 && waited < END_LIMIT);
    repeat (SETTLE) @(posedge clk);

    if (mismatch_total == 0 && results_awaited == 0) begin
      $display("** thermal_video_packet_deframer_unit: PASSED **");
    end else begin
      $display("** thermal_video_packet_deframer_unit: FAILED **");
    end
    $finish;
  end

endmodule

### filelist.f
rtl/tvpd_pkg.sv
rtl/tvpd_if.sv
rtl/thermal_video_packet_deframer_unit.sv
tb/sv/tvpd_deframe_checker.sv
tb/sv/testbench.sv
